[sv/dfl_pkg.sv]
// ----------------------------------------------------------------------------
// dfl_pkg
// Shared types and constants for the box decode block.
// ----------------------------------------------------------------------------
`default_nettype none
package dfl_pkg;
    localparam int BINS_PER_SIDE = 16;
    localparam int CLASS_SLOTS   = 80;
    localparam int MAX_GRID      = 256;
    localparam int BOX_BYTES     = 4 * BINS_PER_SIDE;
    localparam int CELL_BYTES    = BOX_BYTES + CLASS_SLOTS;
    localparam int BIN_W         = $clog2(BINS_PER_SIDE);
    localparam int POS_W         = $clog2(CELL_BYTES);
    localparam int GRID_W        = $clog2(MAX_GRID);

    localparam logic [1:0] OP_LOGIT = 2'd0;
    localparam logic [1:0] OP_EXP   = 2'd1;
    localparam logic [1:0] OP_SIG   = 2'd2;
    localparam logic [1:0] OP_RSVD  = 2'd3;

    localparam logic [2:0] REG_THRESH = 3'd0;
    localparam logic [2:0] REG_CLASS  = 3'd1;
    localparam logic [2:0] REG_GW     = 3'd2;
    localparam logic [2:0] REG_GH     = 3'd3;
    localparam logic [2:0] REG_STRIDE = 3'd4;

    // commands from controller to datapath
    typedef struct packed {
        logic load;      // latch an incoming item
        logic acc;       // add weight into sums
        logic div_start; // begin side division
        logic div_step;  // one quotient bit
        logic div_done;  // store distance, clear sums
        logic box_calc;  // compute box terms
        logic box_out;   // finalize and register result
        logic advance;   // advance byte position
    } dfl_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic [1:0] op;
        logic       is_box;
        logic       last_bin;
        logic       emit;
        logic       div_last;
        logic       out_full;
    } dfl_stat_t;
endpackage
`default_nettype wire

[sv/dfl_datapath.sv]
// ----------------------------------------------------------------------------
// dfl_datapath
// Tables, accumulators, bit-serial divider, box arithmetic and output register.
// ----------------------------------------------------------------------------
`default_nettype none
module dfl_datapath
    import dfl_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire dfl_cmd_t           cmd,
    output dfl_stat_t               stat,
    input  wire logic [1:0]         operation,
    input  wire logic signed [7:0]  logit,
    input  wire logic [7:0]         table_index,
    input  wire logic [31:0]        table_value,
    input  wire logic               cfg_valid,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [31:0]        cfg_data,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [6:0]              class_id,
    output logic [15:0]             score,
    output logic [19:0]             x_center,
    output logic [19:0]             y_center,
    output logic [19:0]             box_width,
    output logic [19:0]             box_height,
    output logic [15:0]             cell_number
);
    // memories
    logic [31:0] exp_mem [256];
    logic [15:0] sig_mem [256];
    logic [31:0] w_reg;
    logic [15:0] s_reg;

    // configuration
    logic signed [7:0] thr_reg;
    logic [6:0]        ccount_reg;
    logic [8:0]        gw_reg, gh_reg;
    logic [7:0]        stride_reg;

    // item and stream state
    logic [1:0]         op_reg;
    logic signed [7:0]  logit_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [GRID_W-1:0]  col_reg, row_reg;
    logic [35:0]        wsum_reg;
    logic [39:0]        bsum_reg;
    logic [15:0]        dist_reg [4];

    // divider
    logic [52:0] rem_reg;
    logic [51:0] quo_reg;
    logic [5:0]  dcnt_reg;
    logic [1:0]  dside_reg;
    logic [35:0] dvs_reg;

    // box terms
    logic signed [23:0] nx_reg, ny_reg;
    logic [16:0]        sw_reg, sh_reg;
    logic [33:0]        px_reg, py_reg;
    logic [24:0]        pw_reg, ph_reg;
    logic               box_ph_reg;

    logic [8:0] gw_lim, gh_lim;
    assign gw_lim = (gw_reg > 9'(MAX_GRID)) ? 9'(MAX_GRID) : gw_reg;
    assign gh_lim = (gh_reg > 9'(MAX_GRID)) ? 9'(MAX_GRID) : gh_reg;

    logic [BIN_W-1:0] bin;
    logic [1:0]       side;
    logic [POS_W-1:0] slot;
    assign bin  = pos_reg[BIN_W-1:0];
    assign side = pos_reg[BIN_W+1:BIN_W];
    assign slot = pos_reg - POS_W'(BOX_BYTES);

    assign stat.op       = op_reg;
    assign stat.is_box   = (pos_reg < POS_W'(BOX_BYTES));
    assign stat.last_bin = (bin == BIN_W'(BINS_PER_SIDE - 1));
    assign stat.emit     = ({1'b0, slot} < {1'b0, POS_W'(ccount_reg)})
                           && (logit_reg > thr_reg);
    assign stat.div_last = (dcnt_reg == 6'd0);
    assign stat.out_full = out_valid;

    // table ports
    always_ff @(posedge clk)
    begin
        if (cmd.load && operation == OP_EXP)
        begin
            exp_mem[table_index] <= table_value;
        end
        if (cmd.load && operation == OP_SIG)
        begin
            sig_mem[table_index] <= table_value[15:0];
        end
        if (cmd.load)
        begin
            w_reg <= exp_mem[logit ^ 8'h80];
            s_reg <= sig_mem[logit ^ 8'h80];
        end
    end

    // divider step
    logic [52:0] rem_sh;
    logic [53:0] trial;
    assign rem_sh = {rem_reg[51:0], quo_reg[51]};
    assign trial  = {1'b0, rem_sh} - {18'd0, dvs_reg};

    logic [51:0] q_fin;
    assign q_fin = quo_reg;

    // box terms, signed
    logic signed [23:0] ax2, ay2;
    assign ax2 = $signed({3'd0, col_reg, 13'd0}) + 24'sd4096;
    assign ay2 = $signed({3'd0, row_reg, 13'd0}) + 24'sd4096;

    logic [15:0] outx_n;
    logic [19:0] cx, cy, bw, bh;
    always_comb
    begin
        cx = (nx_reg < 0) ? 20'd0 : ((px_reg[33:9] > 25'hFFFFF) ? 20'hFFFFF : px_reg[28:9]);
        cy = (ny_reg < 0) ? 20'd0 : ((py_reg[33:9] > 25'hFFFFF) ? 20'hFFFFF : py_reg[28:9]);
        // size products stay below the coordinate ceiling
        bw = {3'd0, pw_reg[24:8]};
        bh = {3'd0, ph_reg[24:8]};
        outx_n = 16'(row_reg * gw_lim + 17'(col_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg    <= '0;
            ccount_reg <= 7'd80;
            gw_reg     <= 9'd80;
            gh_reg     <= 9'd80;
            stride_reg <= 8'd8;
            op_reg     <= OP_LOGIT;
            pos_reg    <= '0;
            col_reg    <= '0;
            row_reg    <= '0;
            wsum_reg   <= '0;
            bsum_reg   <= '0;
            for (int i = 0; i < 4; i++) dist_reg[i] <= '0;
            dcnt_reg   <= '0;
            out_valid  <= 1'b0;
        end
        else
        begin
            // configuration writes
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_THRESH: thr_reg    <= cfg_data[7:0];
                    REG_CLASS:  ccount_reg <= cfg_data[6:0];
                    REG_GW:     gw_reg     <= cfg_data[8:0];
                    REG_GH:     gh_reg     <= cfg_data[8:0];
                    REG_STRIDE: stride_reg <= cfg_data[7:0];
                    default: ;
                endcase
            end
            if (cmd.load)
            begin
                op_reg    <= operation;
                logit_reg <= logit;
            end
            // accumulate
            if (cmd.acc)
            begin
                wsum_reg <= wsum_reg + 36'(w_reg);
                bsum_reg <= bsum_reg + ({8'd0, w_reg} * 40'(bin));
            end
            // division of (bsum << 12) by wsum, one bit a cycle
            if (cmd.div_start)
            begin
                rem_reg   <= '0;
                quo_reg   <= {bsum_reg, 12'd0};
                dvs_reg   <= wsum_reg;
                dcnt_reg  <= 6'd51;
                dside_reg <= side;
            end
            if (cmd.div_step)
            begin
                if (!trial[53])
                begin
                    rem_reg <= trial[52:0];
                    quo_reg <= {quo_reg[50:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh;
                    quo_reg <= {quo_reg[50:0], 1'b0};
                end
                dcnt_reg <= dcnt_reg - 6'd1;
            end
            if (cmd.div_done)
            begin
                if (dvs_reg == '0)
                    dist_reg[dside_reg] <= '0;
                else
                    dist_reg[dside_reg] <= (q_fin > 52'hFFFF) ? 16'hFFFF : q_fin[15:0];
                wsum_reg <= '0;
                bsum_reg <= '0;
            end
            // box stage one: sums; stage two: products
            if (cmd.box_calc)
            begin
                if (!box_ph_reg)
                begin
                    nx_reg <= ax2 - $signed({8'd0, dist_reg[0]}) + $signed({8'd0, dist_reg[2]});
                    ny_reg <= ay2 - $signed({8'd0, dist_reg[1]}) + $signed({8'd0, dist_reg[3]});
                    sw_reg <= {1'b0, dist_reg[0]} + {1'b0, dist_reg[2]};
                    sh_reg <= {1'b0, dist_reg[1]} + {1'b0, dist_reg[3]};
                end
                else
                begin
                    px_reg <= 34'(nx_reg[22:0]) * 34'(stride_reg);
                    py_reg <= 34'(ny_reg[22:0]) * 34'(stride_reg);
                    pw_reg <= 25'(sw_reg) * 25'(stride_reg);
                    ph_reg <= 25'(sh_reg) * 25'(stride_reg);
                end
            end
            // result register
            if (out_valid && !out_stall)
                out_valid <= 1'b0;
            if (cmd.box_out)
            begin
                out_valid   <= 1'b1;
                class_id    <= 7'(slot);
                score       <= s_reg;
                x_center    <= cx;
                y_center    <= cy;
                box_width   <= bw;
                box_height  <= bh;
                cell_number <= outx_n;
            end
            // stream position
            if (cmd.advance)
            begin
                if (pos_reg == POS_W'(CELL_BYTES - 1))
                begin
                    pos_reg <= '0;
                    if (9'(col_reg) + 9'd1 >= gw_lim)
                    begin
                        col_reg <= '0;
                        if (9'(row_reg) + 9'd1 >= gh_lim)
                            row_reg <= '0;
                        else
                            row_reg <= row_reg + 1'b1;
                    end
                    else
                        col_reg <= col_reg + 1'b1;
                end
                else
                    pos_reg <= pos_reg + 1'b1;
            end
        end
    end

    // phase bit of the two-step box computation
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            box_ph_reg <= 1'b0;
        else if (cmd.box_calc)
            box_ph_reg <= ~box_ph_reg;
    end
endmodule
`default_nettype wire

[sv/dfl_ctrl.sv]
// ----------------------------------------------------------------------------
// dfl_ctrl
// Sequencer for one item: fetch, accumulate, divide, box, output.
// ----------------------------------------------------------------------------
`default_nettype none
module dfl_ctrl
    import dfl_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_stall,
    input  wire dfl_stat_t stat,
    output dfl_cmd_t       cmd
);
    typedef enum logic [2:0] {S_IDLE, S_EXEC, S_DIV, S_DONE, S_BOX1, S_BOX2, S_OUT}
        state_t;
    state_t state_reg, state_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        cmd = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (stat.op != OP_LOGIT)
                    state_next = S_IDLE;
                else if (stat.is_box)
                begin
                    cmd.acc = 1'b1;
                    if (stat.last_bin)
                        state_next = S_DIV;
                    else
                    begin
                        cmd.advance = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else if (stat.emit)
                begin
                    cmd.box_calc = 1'b1;
                    state_next = S_BOX2;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_DIV:
            begin
                cmd.div_start = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                    state_next = S_BOX1;
            end
            S_BOX1:
            begin
                cmd.div_done = 1'b1;
                cmd.advance = 1'b1;
                state_next = S_IDLE;
            end
            S_BOX2:
            begin
                cmd.box_calc = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!stat.out_full)
                begin
                    cmd.box_out = 1'b1;
                    cmd.advance = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end
endmodule
`default_nettype wire

[sv/dfl_box_decode_threshold_core.sv]
// ----------------------------------------------------------------------------
// dfl_box_decode_threshold_core
// DFL box decode with one logit threshold shared by all classes, one detection level.
// ----------------------------------------------------------------------------
// Usage:
//   in (in_valid/in_stall) takes one item: a head byte or a table write;
//   cfg (cfg_valid/cfg_ready) writes registers 0..4; the user must do so
//   only while idle, unenforced; out (out_valid/out_stall) gives a detection.
// Sequence:
//   table writes and plain bytes pass load and execute; a non-last bin byte
//   also accumulates; the last bin of a side then runs the one-bit-a-cycle
//   divider (52 quotient bits); a passing class byte runs both box steps, plus
//   any wait for the output register, which holds one item.
// Reset clears the stream position, grid counters, sums and distances and
// loads register defaults; the tables must be written before use.
// While the receiver stalls the finished item holds; a further passing
// class byte waits in the sequencer and the input stays stalled.
// ----------------------------------------------------------------------------
`default_nettype none
module dfl_box_decode_threshold_core
    import dfl_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [1:0]         operation,
    input  wire logic signed [7:0]  logit,
    input  wire logic [7:0]         table_index,
    input  wire logic [31:0]        table_value,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [31:0]        cfg_data,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [6:0]              class_id,
    output logic [15:0]             score,
    output logic [19:0]             x_center,
    output logic [19:0]             y_center,
    output logic [19:0]             box_width,
    output logic [19:0]             box_height,
    output logic [15:0]             cell_number
);
    dfl_cmd_t  cmd;
    dfl_stat_t stat;

    assign cfg_ready = 1'b1;

    dfl_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .stat(stat), .cmd(cmd)
    );

    dfl_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .operation(operation), .logit(logit), .table_index(table_index),
        .table_value(table_value), .cfg_valid(cfg_valid), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .out_valid(out_valid), .out_stall(out_stall),
        .class_id(class_id), .score(score), .x_center(x_center),
        .y_center(y_center), .box_width(box_width), .box_height(box_height),
        .cell_number(cell_number)
    );
endmodule
`default_nettype wire
